FILE: design/assert_macros.svh
// Assertion macros used by the core design file.
// MWC_ASSERT is disabled while arst_n is low; MWC_ASSERT_NR is checked at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MWC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MWC_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MWC_ASSERT(lbl, prop, msg)
`define MWC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

FILE: design/mwc_pkg.sv
package mwc_pkg;

	localparam int MWC_MAX_LEN  = 4096;
	localparam int MWC_ALPHABET = 256;
	localparam int MWC_NEED_W   = $clog2(MWC_MAX_LEN + 1) + 1;

	// Codes of the func field of a request word.
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_PAT   = 2'd1;
	localparam logic [1:0] FUNC_SUB   = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// Codes of the status field of a response word.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_IGNORED = 1'b1;

	// Control of the need table port.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} ntbl_ctl_t;

endpackage

FILE: design/minimum_window_cover_core.sv
// Channel   Handshake            Word
// req       req_valid/req_stall  func, ch
// rsp       rsp_valid/rsp_stall  found, best_start, best_length, status
//
// A start item, an ignored byte or an unused code goes straight to DONE; a pattern byte
// passes PAT first, for its need table read-modify-write.
// A subject byte runs SUB, then SHR_N and SHR_U for every step that shrinks the window,
// each step being a window buffer read followed by a need table read-modify-write.
// Reset is asynchronous and active low; a start item clears the need table.
// A finished word waits in the output register while the next word is taken in;
// if that register is still full at the end of the next word, the core holds.
`include "assert_macros.svh"
module minimum_window_cover_core #(
	parameter int MAX_LEN  = mwc_pkg::MWC_MAX_LEN,
	parameter int ALPHABET = mwc_pkg::MWC_ALPHABET
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  ch,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        found,
	output logic [11:0] best_start,
	output logic [12:0] best_length,
	output logic        status
);

	import mwc_pkg::*;

	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int PW     = $clog2(MAX_LEN);
	localparam int AW     = $clog2(ALPHABET);
	localparam int NEED_W = CNT_W + 1;

	localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_LEN);
	localparam logic signed [NEED_W-1:0] NEED_ONE  = NEED_W'(1);
	localparam logic signed [NEED_W-1:0] NEED_ZERO = '0;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAT   = 3'd1;
	localparam logic [2:0] ST_SUB   = 3'd2;
	localparam logic [2:0] ST_SHR_N = 3'd3;
	localparam logic [2:0] ST_SHR_U = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	// The byte is brought into the alphabet by conditional subtraction of
	// shifted copies of the alphabet size, largest first.
	function automatic logic [AW-1:0] reduce_byte(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		for (int k = 7; k >= 0; k--) begin
			if (int'(r) >= (ALPHABET << k)) begin
				r = r - 8'(ALPHABET << k);
			end
		end
		return AW'(r);
	endfunction

	logic [2:0]       state_q;
	logic [AW-1:0]    byte_q;
	logic [CNT_W-1:0] right_q;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] subj_cnt_q;
	logic [CNT_W-1:0] pat_cnt_q;
	logic [CNT_W-1:0] still_req_q;
	logic [CNT_W-1:0] best_len_q;
	logic [PW-1:0]    best_start_q;
	logic             found_q;
	logic             status_q;

	logic             rsp_valid_q;
	logic             rsp_found_q;
	logic [11:0]      rsp_start_q;
	logic [12:0]      rsp_len_q;
	logic             rsp_status_q;

	logic             req_acc;
	logic             out_free;
	logic [AW-1:0]    byte_in;

	// Window buffer: subject bytes by position.
	logic [AW-1:0]    win_mem [MAX_LEN];
	logic             win_we;
	logic             win_re;
	logic [PW-1:0]    win_wa;
	logic [PW-1:0]    win_ra;
	logic [AW-1:0]    win_rd_s1;

	ntbl_ctl_t                ntbl_ctl;
	logic [AW-1:0]            ntbl_ra;
	logic [AW-1:0]            ntbl_wa;
	logic signed [NEED_W-1:0] ntbl_wd;
	logic signed [NEED_W-1:0] ntbl_rd;

	logic signed [NEED_W-1:0] need_inc;
	logic signed [NEED_W-1:0] need_dec;
	logic [CNT_W-1:0]         sr_sub;
	logic [CNT_W-1:0]         sr_inc;
	logic [CNT_W-1:0]         left_inc;
	logic [CNT_W-1:0]         win_size;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign byte_in   = reduce_byte(ch);

	// Arithmetic on the word read back from the need table.  The need never
	// leaves the range of plus or minus MAX_LEN, so one extra bit carries the sign.
	assign need_inc = ntbl_rd + NEED_ONE;
	assign need_dec = ntbl_rd - NEED_ONE;
	assign sr_sub   = (ntbl_rd > NEED_ZERO) ? still_req_q - 1'b1 : still_req_q;
	assign sr_inc   = (need_inc > NEED_ZERO) ? still_req_q + 1'b1 : still_req_q;
	assign left_inc = left_q + 1'b1;
	assign win_size = right_q - left_q + 1'b1;

	// Memory port control.  Every need table write lands before the next
	// read is issued, so no forwarding path is required.
	always_comb begin
		ntbl_ctl = '0;
		ntbl_ra  = byte_in;
		ntbl_wa  = byte_q;
		ntbl_wd  = need_inc;
		win_we   = 1'b0;
		win_wa   = subj_cnt_q[PW-1:0];
		win_re   = 1'b0;
		win_ra   = left_q[PW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (func)
						FUNC_START: ntbl_ctl.clr = 1'b1;
						FUNC_PAT: ntbl_ctl.rd_en = (pat_cnt_q < CNT_MAX);
						FUNC_SUB: begin
							ntbl_ctl.rd_en = (subj_cnt_q < CNT_MAX);
							win_we         = (subj_cnt_q < CNT_MAX);
						end
						default: ;
					endcase
				end
			end
			ST_PAT: begin
				ntbl_ctl.wr_en = 1'b1;
			end
			ST_SUB: begin
				// Use up the byte's need and fetch the leftmost window byte
				// in case the window now covers the pattern.
				ntbl_ctl.wr_en = 1'b1;
				ntbl_wd        = need_dec;
				win_re         = 1'b1;
			end
			ST_SHR_N: begin
				ntbl_ctl.rd_en = 1'b1;
				ntbl_ra        = win_rd_s1;
			end
			ST_SHR_U: begin
				// Give the dropped byte back and prefetch the next left byte.
				ntbl_ctl.wr_en = 1'b1;
				win_re         = 1'b1;
				win_ra         = left_inc[PW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_wa] <= byte_in;
		end
		if (win_re) begin
			win_rd_s1 <= win_mem[win_ra];
		end
	end

	mwc_need_tbl #(
		.ALPHABET (ALPHABET),
		.NEED_W   (NEED_W)
	) u_need_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ntbl_ctl),
		.rd_addr (ntbl_ra),
		.wr_addr (ntbl_wa),
		.wr_data (ntbl_wd),
		.rd_data (ntbl_rd)
	);

	// Sequencer.  A subject byte runs SUB once and then alternates SHR_N and
	// SHR_U for as long as the window covers the pattern and is not empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			byte_q       <= '0;
			right_q      <= '0;
			left_q       <= '0;
			subj_cnt_q   <= '0;
			pat_cnt_q    <= '0;
			still_req_q  <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			found_q      <= 1'b0;
			status_q     <= STATUS_OK;
			rsp_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						status_q <= STATUS_OK;
						case (func)
							FUNC_START: begin
								left_q       <= '0;
								subj_cnt_q   <= '0;
								pat_cnt_q    <= '0;
								still_req_q  <= '0;
								best_len_q   <= '0;
								best_start_q <= '0;
								found_q      <= 1'b0;
								state_q      <= ST_DONE;
							end
							FUNC_PAT: begin
								if (pat_cnt_q >= CNT_MAX) begin
									status_q <= STATUS_IGNORED;
									state_q  <= ST_DONE;
								end else begin
									byte_q  <= byte_in;
									state_q <= ST_PAT;
								end
							end
							FUNC_SUB: begin
								if (subj_cnt_q >= CNT_MAX) begin
									status_q <= STATUS_IGNORED;
									state_q  <= ST_DONE;
								end else begin
									byte_q     <= byte_in;
									right_q    <= subj_cnt_q;
									subj_cnt_q <= subj_cnt_q + 1'b1;
									state_q    <= ST_SUB;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PAT: begin
					pat_cnt_q   <= pat_cnt_q + 1'b1;
					still_req_q <= sr_inc;
					state_q     <= ST_DONE;
				end
				ST_SUB: begin
					still_req_q <= sr_sub;
					if (sr_sub == '0 && left_q <= right_q) begin
						state_q <= ST_SHR_N;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SHR_N: begin
					// Only a strictly shorter window replaces the best one.
					byte_q <= win_rd_s1;
					if (!found_q || win_size < best_len_q) begin
						found_q      <= 1'b1;
						best_len_q   <= win_size;
						best_start_q <= left_q[PW-1:0];
					end
					state_q <= ST_SHR_U;
				end
				ST_SHR_U: begin
					still_req_q <= sr_inc;
					left_q      <= left_inc;
					if (sr_inc == '0 && left_inc <= right_q) begin
						state_q <= ST_SHR_N;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_found_q  <= found_q;
			rsp_start_q  <= found_q ? 12'(best_start_q) : '0;
			rsp_len_q    <= found_q ? 13'(best_len_q) : '0;
			rsp_status_q <= status_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign found       = rsp_found_q;
	assign best_start  = rsp_start_q;
	assign best_length = rsp_len_q;
	assign status      = rsp_status_q;

	`MWC_ASSERT(a_left_bound, left_q <= subj_cnt_q, "left edge passed the stored bytes")
	`MWC_ASSERT(a_none_zero, !found_q |-> (best_len_q == '0 && best_start_q == '0), "stale best")
	`MWC_ASSERT(a_best_len, found_q |-> (best_len_q != '0 && best_len_q <= subj_cnt_q), "bad length")
	`MWC_ASSERT(a_req_bound, still_req_q <= pat_cnt_q, "required count exceeds pattern length")

endmodule

FILE: design/mwc_need_tbl.sv
module mwc_need_tbl #(
	parameter int ALPHABET = mwc_pkg::MWC_ALPHABET,
	parameter int NEED_W   = mwc_pkg::MWC_NEED_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mwc_pkg::ntbl_ctl_t          ctl,
	input  logic [$clog2(ALPHABET)-1:0] rd_addr,
	input  logic [$clog2(ALPHABET)-1:0] wr_addr,
	input  logic signed [NEED_W-1:0]    wr_data,
	output logic signed [NEED_W-1:0]    rd_data
);

	logic signed [NEED_W-1:0] mem [ALPHABET];
	logic [ALPHABET-1:0]      vld_q;
	logic                     rd_vld_s1;
	logic signed [NEED_W-1:0] mem_rd_s1;

	// An entry that has not been written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_s1 ? mem_rd_s1 : '0;

endmodule

FILE: dv/minimum_window_cover_core_test.sv
module minimum_window_cover_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mwc_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYCLES = 5;
	// The limit leaves a wide margin over the length of a whole run.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Wait after the last result is in, for any stray word to show itself.
	localparam int TAIL_CYCLES = 32;

	// Operation carried in the func field of a request word.
	typedef enum logic [1:0] {
		FN_START   = FUNC_START,
		FN_PATTERN = FUNC_PAT,
		FN_SUBJECT = FUNC_SUB,
		FN_UNUSED  = FUNC_NONE
	} mwc_func_t;

	// One response word, laid out as the core's output ports.
	typedef struct packed {
		logic        found;
		logic [11:0] best_start;
		logic [12:0] best_length;
		logic        status;
	} window_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  func = FN_START;
	logic [7:0]  ch = 8'h00;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        found;
	logic [11:0] best_start;
	logic [12:0] best_length;
	logic        status;

	minimum_window_cover_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.ch         (ch),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.found      (found),
		.best_start (best_start),
		.best_length(best_length),
		.status     (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Percentages that shape the traffic on each side; each test sets its own.
	int idle_pct  = 0;
	int stall_pct = 0;

	int fail_count  = 0;
	int cycle_count = 0;

	// Our own copy of the search state. The need of a byte is signed: a negative
	// value means the current window holds more of that byte than the pattern asks.
	logic signed [MWC_NEED_W-1:0] byte_need [MWC_ALPHABET];
	logic [7:0]                   held_bytes [MWC_MAX_LEN];
	logic [12:0]                  left_edge;
	logic [12:0]                  subj_len;
	logic [12:0]                  pat_len;
	logic [12:0]                  missing;
	logic [12:0]                  best_len;
	logic [11:0]                  best_pos;
	logic                         have_cover;

	// Response words still owed by the core, oldest first.
	window_word_t awaited_windows [$];

	function automatic void clear_problem_state();
		foreach (byte_need[i])
			byte_need[i] = '0;
		left_edge  = '0;
		subj_len   = '0;
		pat_len    = '0;
		missing    = '0;
		best_len   = '0;
		best_pos   = '0;
		have_cover = 1'b0;
	endfunction

	// Applies one request word to our copy of the state and returns the response
	// word that the core must give for it.
	function automatic window_word_t next_best_window(input mwc_func_t fn, input logic [7:0] c);
		window_word_t w;
		logic [12:0]  right_edge;
		logic [7:0]   dropped;
		w = '0;
		w.status = STATUS_OK;
		case (fn)
			FN_START: begin
				clear_problem_state();
			end
			FN_PATTERN: begin
				if (pat_len >= MWC_MAX_LEN) begin
					w.status = STATUS_IGNORED;
				end else begin
					pat_len++;
					byte_need[c]++;
					if (byte_need[c] > 0)
						missing++;
				end
			end
			FN_SUBJECT: begin
				if (subj_len >= MWC_MAX_LEN) begin
					w.status = STATUS_IGNORED;
				end else begin
					right_edge = subj_len;
					held_bytes[right_edge] = c;
					subj_len++;
					if (byte_need[c] > 0)
						missing--;
					byte_need[c]--;
					// Shrink from the left while the window still covers the
					// pattern; the loop also stops once the window is empty, which
					// is what an empty pattern relies on. Only a strictly shorter
					// window replaces the best one, so the earliest one stays.
					while (missing == 0 && left_edge <= right_edge) begin
						if (!have_cover || (right_edge - left_edge + 1) < best_len) begin
							have_cover = 1'b1;
							best_len   = right_edge - left_edge + 1;
							best_pos   = left_edge[11:0];
						end
						dropped = held_bytes[left_edge];
						byte_need[dropped]++;
						if (byte_need[dropped] > 0)
							missing++;
						left_edge++;
					end
				end
			end
			default: begin
				// The unused code leaves everything as it is.
			end
		endcase
		w.found       = have_cover;
		w.best_start  = have_cover ? best_pos : '0;
		w.best_length = have_cover ? best_len : '0;
		return w;
	endfunction

	// The receiver stalls at random, at the rate the current test asks for.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Every response word taken is held against the oldest word still owed.
	// Outputs are read before the edge's own updates land, so the values seen
	// are the ones the core presented for this edge.
	always @(posedge clk) begin
		window_word_t owed;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_windows.size() == 0) begin
				$error("response word arrived while none was owed");
				fail_count++;
			end else begin
				owed = awaited_windows.pop_front();
				if (found !== owed.found) begin
					$error("found: expected %0d, actual %0d", owed.found, found);
					fail_count++;
				end
				if (best_start !== owed.best_start) begin
					$error("best_start: expected %0d, actual %0d", owed.best_start, best_start);
					fail_count++;
				end
				if (best_length !== owed.best_length) begin
					$error("best_length: expected %0d, actual %0d",
						owed.best_length, best_length);
					fail_count++;
				end
				if (status !== owed.status) begin
					$error("status: expected %0d, actual %0d", owed.status, status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung core or a lost word ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offers one request word and returns at the edge where it is taken. The
	// valid line stays high into the next call, so back-to-back words need no
	// gap; it only drops when the sender decides to idle.
	task automatic send_word(input mwc_func_t fn, input logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= fn;
		ch        <= c;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		awaited_windows.push_back(next_best_window(fn, c));
	endtask

	// The sender holds back until every owed word has come out of the core.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_windows.size() != 0);
	endtask

	// A short hand-written sequence: the unused code, an empty pattern, the end
	// values of the byte, a pattern byte arriving after subject bytes both with
	// and without a surplus in the window.
	task automatic test_directed_cases();
		idle_pct  = 34;
		stall_pct = 34;
		send_word(FN_START, 8'hFF);
		send_word(FN_UNUSED, 8'h00);
		send_word(FN_SUBJECT, 8'h00);
		send_word(FN_SUBJECT, 8'hFF);
		send_word(FN_UNUSED, 8'hFF);
		send_word(FN_START, 8'h00);
		send_word(FN_PATTERN, 8'h00);
		send_word(FN_PATTERN, 8'hFF);
		send_word(FN_PATTERN, 8'hFF);
		send_word(FN_SUBJECT, 8'hFF);
		send_word(FN_SUBJECT, 8'h7F);
		send_word(FN_SUBJECT, 8'h00);
		send_word(FN_SUBJECT, 8'h80);
		send_word(FN_SUBJECT, 8'hFF);
		send_word(FN_SUBJECT, 8'h80);
		send_word(FN_PATTERN, 8'h80);
		send_word(FN_PATTERN, 8'h01);
		send_word(FN_SUBJECT, 8'h55);
		send_word(FN_SUBJECT, 8'h01);
		send_word(FN_SUBJECT, 8'hAA);
		send_word(FN_UNUSED, 8'h5A);
		wait_for_results();
	endtask

	// Mostly well-formed problems: a start, a short pattern drawn from a small
	// random alphabet and a subject drawn mainly from the same alphabet, so that
	// covering windows come and go often. Now and then the start is left out, a
	// stray byte, a late pattern byte or the unused code is mixed in.
	task automatic test_random_problems(input int idle, input int stall, input int word_budget);
		logic [7:0] letters [4];
		int         sent;
		int         pick;
		sent      = 0;
		idle_pct  = idle;
		stall_pct = stall;
		while (sent < word_budget) begin
			foreach (letters[i])
				letters[i] = 8'($urandom_range(255));
			if ($urandom_range(9) != 0) begin
				send_word(FN_START, 8'($urandom_range(255)));
				sent++;
			end
			repeat ($urandom_range(5)) begin
				send_word(FN_PATTERN, letters[$urandom_range(3)]);
				sent++;
			end
			repeat ($urandom_range(1, 30)) begin
				pick = $urandom_range(99);
				if (pick < 85)
					send_word(FN_SUBJECT, letters[$urandom_range(3)]);
				else if (pick < 93)
					send_word(FN_SUBJECT, 8'($urandom_range(255)));
				else if (pick < 97)
					send_word(FN_PATTERN, letters[$urandom_range(3)]);
				else
					send_word(FN_UNUSED, 8'($urandom_range(255)));
				sent++;
			end
		end
		wait_for_results();
	endtask

	initial begin
		clear_problem_state();
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		// The random part runs through each traffic pattern in turn: a clean
		// stream, a sparse sender, a sluggish receiver, and both at once.
		test_random_problems(0, 0, 400);
		test_random_problems(63, 0, 400);
		test_random_problems(0, 63, 400);
		test_random_problems(34, 34, 400);

		// Let any stray word show itself before the verdict.
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
